/* design/mtxa_pkg.sv */
// Shared types and constants for the mutex slot allocator.
// Holds command and status codes, field widths and the request/result structs.
// No dependencies.
`timescale 1ns / 1ps

package mtxa_pkg;

    localparam int CMD_W  = 2;
    localparam int REF_W  = 8;
    localparam int PID_W  = 22;
    localparam int STAT_W = 2;
    localparam int ID_W   = 8;
    localparam int CNT_W  = 6;

    typedef enum logic [CMD_W-1:0] {
        CMD_ACQUIRE = 2'd0,
        CMD_RELEASE = 2'd1,
        CMD_QUERY   = 2'd2
    } t_cmd;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } t_status;

    // Members are listed from the highest bit down, so the first field of the
    // stream word sits in the lowest bits.
    typedef struct packed {
        logic [PID_W-1:0] requester_pid;
        logic [REF_W-1:0] mutex_ref;
        logic [CMD_W-1:0] command;
    } t_request;

    typedef struct packed {
        logic [CNT_W-1:0] busy_count;
        logic [PID_W-1:0] slot_owner;
        logic             slot_busy;
        logic [ID_W-1:0]  granted_id;
        t_status          status;
    } t_result;

endpackage

/* design/mtxa_find_free.sv */
// Priority encoder that finds the lowest free slot in the used-bit vector.
// Depends on nothing but its parameter.
`timescale 1ns / 1ps

module mtxa_find_free #(
    parameter int SLOT_COUNT = 8,
    parameter int SLOT_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1
) (
    input  logic [SLOT_COUNT-1:0] i_used,
    output logic                  o_found,
    output logic [SLOT_W-1:0]     o_index
);

    always_comb begin
        o_found = 1'b0;
        o_index = '0;
        // Walk from the top down so the lowest free slot wins.
        for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
            if (!i_used[i]) begin
                o_found = 1'b1;
                o_index = SLOT_W'(i);
            end
        end
    end

endmodule

/* design/mtxa_slot_table.sv */
// Slot state (used bits, owner ids, busy count) and the command logic that
// reads and updates it. Uses mtxa_pkg and mtxa_find_free.
`timescale 1ns / 1ps

module mtxa_slot_table #(
    parameter int SLOT_COUNT = 8,
    parameter int ID_OFFSET  = 5
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_exec,
    input  mtxa_pkg::t_request i_req,
    output mtxa_pkg::t_result  o_res
);

    localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

    logic [SLOT_COUNT-1:0]        r_used;
    logic [SLOT_COUNT-1:0]        n_used;
    logic [mtxa_pkg::CNT_W-1:0]   r_count;
    logic [mtxa_pkg::CNT_W-1:0]   n_count;
    logic [mtxa_pkg::PID_W-1:0]   r_owner [SLOT_COUNT];

    logic                         free_found;
    logic [SLOT_W-1:0]            free_idx;
    logic                         grant;
    logic [mtxa_pkg::ID_W:0]      rel_diff;
    logic                         rel_ok;
    logic [SLOT_W-1:0]            rel_idx;
    logic                         qry_ok;
    logic [SLOT_W-1:0]            qry_idx;

    mtxa_find_free #(
        .SLOT_COUNT (SLOT_COUNT),
        .SLOT_W     (SLOT_W)
    ) u_find_free (
        .i_used  (r_used),
        .o_found (free_found),
        .o_index (free_idx)
    );

    // Release ids carry the offset; a borrow out of the subtraction means the
    // id lies below the pool.
    assign rel_diff = {1'b0, i_req.mutex_ref} - (mtxa_pkg::ID_W + 1)'(ID_OFFSET);
    assign rel_ok   = !rel_diff[mtxa_pkg::ID_W] &&
                      (rel_diff[mtxa_pkg::ID_W-1:0] < mtxa_pkg::ID_W'(SLOT_COUNT));
    assign rel_idx  = rel_diff[SLOT_W-1:0];
    assign qry_ok   = i_req.mutex_ref < mtxa_pkg::REF_W'(SLOT_COUNT);
    assign qry_idx  = i_req.mutex_ref[SLOT_W-1:0];

    always_comb begin
        n_used           = r_used;
        n_count          = r_count;
        grant            = 1'b0;
        o_res.status     = mtxa_pkg::ST_RANGE;
        o_res.granted_id = '0;
        o_res.slot_busy  = 1'b0;
        o_res.slot_owner = '0;
        case (mtxa_pkg::t_cmd'(i_req.command))
            mtxa_pkg::CMD_ACQUIRE: begin
                o_res.status = mtxa_pkg::ST_FULL;
                if (free_found) begin
                    grant            = 1'b1;
                    n_used[free_idx] = 1'b1;
                    n_count          = r_count + mtxa_pkg::CNT_W'(1);
                    o_res.status     = mtxa_pkg::ST_OK;
                    o_res.granted_id = mtxa_pkg::ID_W'(free_idx) +
                                       mtxa_pkg::ID_W'(ID_OFFSET);
                end
            end
            mtxa_pkg::CMD_RELEASE: begin
                if (rel_ok) begin
                    o_res.status = mtxa_pkg::ST_OK;
                    if (r_used[rel_idx]) begin
                        n_count = r_count - mtxa_pkg::CNT_W'(1);
                    end
                    n_used[rel_idx] = 1'b0;
                end
            end
            mtxa_pkg::CMD_QUERY: begin
                if (qry_ok) begin
                    o_res.status = mtxa_pkg::ST_OK;
                    if (r_used[qry_idx]) begin
                        o_res.slot_busy  = 1'b1;
                        o_res.slot_owner = r_owner[qry_idx];
                    end
                end
            end
            default: begin
            end
        endcase
        o_res.busy_count = n_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used  <= '0;
            r_count <= '0;
        end else if (i_exec) begin
            r_used  <= n_used;
            r_count <= n_count;
        end
    end

    // A released slot keeps its old owner; it is masked by the used bit.
    always_ff @(posedge i_clk) begin
        if (i_exec && grant) begin
            r_owner[free_idx] <= i_req.requester_pid;
        end
    end

    a_count_matches_bits : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count == mtxa_pkg::CNT_W'($countones(r_used)))
        else $error("busy count disagrees with the used bits");

    a_count_bounded : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= mtxa_pkg::CNT_W'(SLOT_COUNT))
        else $error("busy count exceeds the pool size");

    a_full_only_when_all_used : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_exec && o_res.status == mtxa_pkg::ST_FULL) |-> (&r_used))
        else $error("pool reported full while a slot is free");

endmodule

/* design/hw_mutex_slot_allocator_core.sv */
// Top level of the mutex slot allocator: stream ports, input register and
// result register around the slot table. Uses mtxa_pkg and mtxa_slot_table.
`timescale 1ns / 1ps

// The allocator takes one command transfer per clock cycle on the slave
// stream while the master side takes results, and returns exactly one result
// transfer per command on the master stream, in order. A command waits in the
// input register, where the slot table decodes it, finds the lowest free
// slot with a priority encoder and updates its used bits, owner ids and busy
// count; the result is captured in the output register at the same edge that
// writes that state. Because the state is written at that edge, the next
// command sees it immediately and the sustained rate is one command per
// cycle as long as the master side takes results. Back pressure from
// m_axis_tready stalls both registers together; the input register still
// accepts a new command while it is empty, even if a finished result waits.
// Acquire returns the granted slot plus ID_OFFSET, release expects that
// offset id, and query takes the raw slot index. Reset empties the pool and
// clears the busy count; no clearing pass is needed.

module hw_mutex_slot_allocator_core #(
    parameter int SLOT_COUNT = 8,
    parameter int ID_OFFSET  = 5
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // Fields from bit 0 up: command[1:0], mutex_ref[9:2], requester_pid[31:10].
    input  logic [31:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // Fields from bit 0 up: status[1:0], granted_id[9:2], slot_busy[10],
    // slot_owner[32:11], busy_count[38:33], zero fill[39].
    output logic [39:0] m_axis_tdata
);

    logic               r_in_valid;
    mtxa_pkg::t_request r_in;
    logic               r_out_valid;
    mtxa_pkg::t_result  r_out;

    mtxa_pkg::t_result  step_res;
    logic               advance;
    logic               exec;

    // The result register can load when it is empty or being drained.
    assign advance       = !r_out_valid || m_axis_tready;
    assign exec          = r_in_valid && advance;
    assign s_axis_tready = !r_in_valid || advance;

    mtxa_slot_table #(
        .SLOT_COUNT (SLOT_COUNT),
        .ID_OFFSET  (ID_OFFSET)
    ) u_slot_table (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_exec  (exec),
        .i_req   (r_in),
        .o_res   (step_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in <= mtxa_pkg::t_request'(s_axis_tdata);
        end
        if (exec) begin
            r_out <= step_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {1'b0, r_out};

    // A new result can only appear after a command sat in the input register.
    a_result_has_command : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_in_valid))
        else $error("result appeared without a pending command");

endmodule
